/* rtl/ogn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ogn_pkg
// Shared widths, codes, control types and helper functions for the octave
// gradient noise pipeline.
// ----------------------------------------------------------------------------
package ogn_pkg;

  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned COORD_W    = 28;
  localparam int unsigned OUT_W      = 19;
  localparam int unsigned GRAD_W     = 19;
  localparam int unsigned LERP_W     = 20;
  localparam int unsigned FADE_W     = 17;
  localparam int unsigned PFAC_W     = 20;
  localparam int unsigned HASH_W     = 3;
  localparam int unsigned PIPE_DEPTH = 10;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd131072;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef struct packed {
    logic vld;
    logic load;
  } ogn_ctl_t;

  typedef struct packed {
    logic a_we;
    logic bc_we;
  } ogn_wr_t;

  // gradient dot product for one corner, h is the low hash bits
  function automatic logic signed [GRAD_W-1:0] grad(
    input logic [HASH_W-1:0]       h,
    input logic signed [FRAC_W+1:0] x,
    input logic signed [FRAC_W+1:0] y
  );
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    u = h[2] ? GRAD_W'(y) : GRAD_W'(x);
    v = h[2] ? GRAD_W'(x) : GRAD_W'(y);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  // product scaled down by 2^16, rounding toward zero
  function automatic logic signed [LERP_W+1:0] div16_tz(input logic signed [39:0] p);
    logic signed [39:0] adj;
    adj = p + ((p < 0) ? 40'sd65535 : 40'sd0);
    return (LERP_W+2)'(adj >>> FRAC_W);
  endfunction

endpackage
`default_nettype wire

/* rtl/ogn_octave.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ogn_octave
// One octave lane: fade curves, two-level permutation lookups, corner
// gradients and bilinear blend, seven register stages deep.
// ----------------------------------------------------------------------------
module ogn_octave
  import ogn_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire ogn_wr_t                  wr_i,
  input  wire logic [CELL_W-1:0]        ld_idx0_i,
  input  wire logic [CELL_W-1:0]        ld_val0_i,
  input  wire logic [CELL_W-1:0]        ld_idx1_i,
  input  wire logic [CELL_W-1:0]        ld_val1_i,
  input  wire logic [CELL_W-1:0]        cell_x_i,
  input  wire logic [CELL_W-1:0]        cell_y_i,
  input  wire logic [FRAC_W-1:0]        frac_x_i,
  input  wire logic [FRAC_W-1:0]        frac_y_i,
  output logic signed [LERP_W-1:0]      noise_o
);

  // first-level copy is read at cx and cx+1, the two hash copies keep
  // only the bits the gradient choice needs
  logic [CELL_W-1:0] perm_a [256];
  logic [HASH_W-1:0] perm_b [256];
  logic [HASH_W-1:0] perm_c [256];

  // stage 1
  logic [CELL_W-1:0]   pa0_q, pa1_q, cy1_q;
  logic [FRAC_W-1:0]   f1_q  [2];
  logic [2*FRAC_W-1:0] sq1_q [2];
  // stage 2
  logic [HASH_W-1:0]   h00_q, h10_q, h01_q, h11_q;
  logic [FRAC_W-1:0]   f2_q  [2];
  logic [FRAC_W-1:0]   t3_q  [2];
  logic [PFAC_W-1:0]   p2_q  [2];
  // stage 3
  logic signed [GRAD_W-1:0] g00_q, g10_q, g01_q, g11_q;
  logic [FADE_W-1:0]   fade_q [2];
  // stage 4
  logic signed [37:0]       prod0_q, prod1_q;
  logic signed [GRAD_W-1:0] g00_4_q, g01_4_q;
  logic [FADE_W-1:0]        v4_q;
  // stage 5
  logic signed [LERP_W-1:0] n0_q, n1_q;
  logic [FADE_W-1:0]        v5_q;
  // stage 6
  logic signed [38:0]       prod2_q;
  logic signed [LERP_W-1:0] n0_6_q;
  // stage 7
  logic signed [LERP_W-1:0] noise_q;

  logic [FRAC_W-1:0]   frac_in [2];
  logic [CELL_W-1:0]   addr_a, addr_b;
  logic [2*FRAC_W-1:0] sq_d [2];
  logic [2*FRAC_W-1:0] t3_full [2];
  logic [34:0]         six_full [2];
  logic [20:0]         p_full [2];
  logic [35:0]         fade_full [2];
  logic signed [FRAC_W+1:0] x0, x1, y0, y1;
  logic signed [LERP_W:0]   d2;

  assign frac_in[0] = frac_x_i;
  assign frac_in[1] = frac_y_i;

  assign addr_a = pa0_q + cy1_q;
  assign addr_b = pa1_q + cy1_q;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sq_d[a]      = {16'b0, frac_in[a]} * {16'b0, frac_in[a]};
      t3_full[a]   = {16'b0, sq1_q[a][31:16]} * {16'b0, f1_q[a]};
      six_full[a]  = 35'(sq1_q[a]) * 35'd6;
      p_full[a]    = 21'd655360 + 21'(six_full[a][34:16]) - 21'(20'(f1_q[a]) * 20'd15);
      fade_full[a] = 36'(t3_q[a]) * 36'(p2_q[a]);
    end
  end

  // corner offsets: frac and frac - 1
  assign x0 = $signed({2'b00, f2_q[0]});
  assign x1 = $signed({2'b11, f2_q[0]});
  assign y0 = $signed({2'b00, f2_q[1]});
  assign y1 = $signed({2'b11, f2_q[1]});

  assign d2 = (LERP_W+1)'(n1_q) - (LERP_W+1)'(n0_q);

  always_ff @(posedge clk_i) begin
    if (wr_i.a_we) begin
      perm_a[ld_idx0_i] <= ld_val0_i;
    end
    if (en_i) begin
      pa0_q <= perm_a[cell_x_i];
      pa1_q <= perm_a[cell_x_i + 8'd1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.bc_we) begin
      perm_b[ld_idx1_i] <= ld_val1_i[HASH_W-1:0];
      perm_c[ld_idx1_i] <= ld_val1_i[HASH_W-1:0];
    end
    if (en_i) begin
      h00_q <= perm_b[addr_a];
      h10_q <= perm_b[addr_b];
      h01_q <= perm_c[addr_a + 8'd1];
      h11_q <= perm_c[addr_b + 8'd1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cy1_q <= cell_y_i;
      for (int a = 0; a < 2; a++) begin
        f1_q[a]   <= frac_in[a];
        sq1_q[a]  <= sq_d[a];
        f2_q[a]   <= f1_q[a];
        t3_q[a]   <= t3_full[a][31:16];
        p2_q[a]   <= p_full[a][PFAC_W-1:0];
        fade_q[a] <= fade_full[a][32:16];
      end
      g00_q <= grad(h00_q, x0, y0);
      g10_q <= grad(h10_q, x1, y0);
      g01_q <= grad(h01_q, x0, y1);
      g11_q <= grad(h11_q, x1, y1);

      prod0_q <= 38'($signed({1'b0, fade_q[0]})) * 38'(20'(g10_q) - 20'(g00_q));
      prod1_q <= 38'($signed({1'b0, fade_q[0]})) * 38'(20'(g11_q) - 20'(g01_q));
      g00_4_q <= g00_q;
      g01_4_q <= g01_q;
      v4_q    <= fade_q[1];

      n0_q <= LERP_W'((LERP_W+2)'(g00_4_q) + div16_tz(40'(prod0_q)));
      n1_q <= LERP_W'((LERP_W+2)'(g01_4_q) + div16_tz(40'(prod1_q)));
      v5_q <= v4_q;

      prod2_q <= 39'($signed({1'b0, v5_q})) * 39'(d2);
      n0_6_q  <= n0_q;

      noise_q <= LERP_W'((LERP_W+2)'(n0_6_q) + div16_tz(40'(prod2_q)));
    end
  end

  assign noise_o = noise_q;

endmodule
`default_nettype wire

/* rtl/octave_gradient_noise_2d.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octave_gradient_noise_2d
// Fractal 2D gradient noise over OCTAVES octaves with a loadable
// permutation table.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output side keeps up and returns one
// noise sample per query item. Every octave has its own seven-stage lane
// with three copies of the permutation table, so each lane's two first-level
// lookups share the first stage and its four hash lookups share the second;
// a weighted sum, a split constant multiply and a round/saturate stage follow.
// A load item (mode 0) writes the table copies as it passes through the
// first two stages and gives no result. Table entries must be loaded before
// queries reach them. A stall at the output holds the whole pipeline.
module octave_gradient_noise_2d
  import ogn_pkg::*;
#(
  parameter int unsigned OCTAVES = 4
)
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      mode_i,
  input  wire logic [CELL_W-1:0]         table_index_i,
  input  wire logic [CELL_W-1:0]         table_value_i,
  input  wire logic signed [COORD_W-1:0] coord_x_i,
  input  wire logic signed [COORD_W-1:0] coord_y_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [OUT_W-1:0]        noise_value_o
);

  localparam int unsigned SumW = LERP_W + OCTAVES + 1;
  localparam int unsigned TotW = SumW + 34;
  localparam int unsigned QuoW = SumW + 2;
  localparam logic [32:0] NormRecip =
    33'((64'd1 << 32) / ((64'd1 << OCTAVES) - 64'd1) + 64'd1);
  localparam logic [15:0] RecipLo = NormRecip[15:0];
  localparam logic [16:0] RecipHi = NormRecip[32:16];

  ogn_ctl_t ctl_q [1:PIPE_DEPTH];
  logic     en;
  logic     in_load;
  ogn_wr_t  wr;

  logic [CELL_W-1:0] ld_idx1_q, ld_val1_q;

  logic signed [LERP_W-1:0] oct_n [OCTAVES];

  logic signed [SumW-1:0]    sum_d, sum_q;
  logic signed [SumW+16:0]   plo_q;
  logic signed [SumW+17:0]   phi_q;
  logic signed [TotW-1:0]    total, rnd;
  logic signed [QuoW-1:0]    quo, sat;
  logic signed [OUT_W-1:0]   noise_q;

  assign out_valid_o = ctl_q[PIPE_DEPTH].vld & ~ctl_q[PIPE_DEPTH].load;
  assign in_stall_o  = out_valid_o & out_stall_i;
  assign en          = ~in_stall_o;
  assign in_load     = (mode_i == MODE_LOAD);

  assign wr.a_we  = en & in_valid_i & in_load;
  assign wr.bc_we = en & ctl_q[1].vld & ctl_q[1].load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= PIPE_DEPTH; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en) begin
      ctl_q[1] <= '{vld: in_valid_i, load: in_load};
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < OCTAVES; i++) begin : g_oct
    logic [CELL_W+FRAC_W-1:0] xs, ys;
    // octave i samples at coordinate * 2^i; only cell and fraction bits matter
    assign xs = (CELL_W+FRAC_W)'(coord_x_i << i);
    assign ys = (CELL_W+FRAC_W)'(coord_y_i << i);

    ogn_octave u_oct (
      .clk_i     (clk_i),
      .en_i      (en),
      .wr_i      (wr),
      .ld_idx0_i (table_index_i),
      .ld_val0_i (table_value_i),
      .ld_idx1_i (ld_idx1_q),
      .ld_val1_i (ld_val1_q),
      .cell_x_i  (xs[CELL_W+FRAC_W-1:FRAC_W]),
      .cell_y_i  (ys[CELL_W+FRAC_W-1:FRAC_W]),
      .frac_x_i  (xs[FRAC_W-1:0]),
      .frac_y_i  (ys[FRAC_W-1:0]),
      .noise_o   (oct_n[i])
    );
  end

  // weight 2^(OCTAVES-1-i) for octave i
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < OCTAVES; i++) begin
      sum_d = sum_d + (SumW'(oct_n[i]) <<< (OCTAVES - 1 - i));
    end
  end

  always_comb begin
    total = (TotW'(phi_q) <<< 16) + TotW'(plo_q);
    rnd   = (total < 0) ? TotW'(64'h0000_0000_FFFF_FFFF) : '0;
    quo   = QuoW'((total + rnd) >>> 32);
    if (quo > QuoW'(OUT_MAX)) begin
      sat = QuoW'(OUT_MAX);
    end else if (quo < -QuoW'(OUT_MAX)) begin
      sat = -QuoW'(OUT_MAX);
    end else begin
      sat = quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ld_idx1_q <= table_index_i;
      ld_val1_q <= table_value_i;
      sum_q     <= sum_d;
      // normalizing multiply split into two partial products
      plo_q     <= (SumW+17)'(sum_q) * (SumW+17)'($signed({1'b0, RecipLo}));
      phi_q     <= (SumW+18)'(sum_q) * (SumW+18)'($signed({1'b0, RecipHi}));
      noise_q   <= OUT_W'(sat);
    end
  end

  assign noise_value_o = noise_q;

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(ctl_q[1]) && $stable(ctl_q[PIPE_DEPTH/2]))
    else $error("pipeline control moved during a stall");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (noise_value_o <= OUT_MAX) && (noise_value_o >= -OUT_MAX))
    else $error("noise sample outside saturation range");

endmodule
`default_nettype wire

/* tb/sv/tb_octave_gradient_noise_2d.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_octave_gradient_noise_2d
// Loads the permutation table, then drives directed and random noise queries
// mixed with table reloads, and checks every sample against a fixed-point
// octave noise predictor under random idling and output stalls.
// ----------------------------------------------------------------------------

class noise_scoreboard;
  logic [7:0] perm[256];
  logic signed [18:0] pending[$];
  int errors;
  int checked;

  function longint fade(longint f);
    longint t3, p;
    t3 = (((f * f) / 65536) * f) / 65536;
    p = 10 * 65536 + (6 * f * f) / 65536 - 15 * f;
    return (t3 * p) / 65536;
  endfunction

  function longint grad(int hash, longint x, longint y);
    int h;
    longint u, v;
    h = hash & 7;
    u = (h < 4) ? x : y;
    v = (h < 4) ? y : x;
    return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
  endfunction

  function longint lerp(longint a, longint b, longint t);
    return a + (t * (b - a)) / 65536;
  endfunction

  function longint octave_sample(longint xs, longint ys);
    int cx, cy, a, b;
    longint fx, fy, u, v, g00, g10, g01, g11;
    cx = int'((xs >>> 16) & 255);
    cy = int'((ys >>> 16) & 255);
    fx = xs & 16'hFFFF;
    fy = ys & 16'hFFFF;
    u = fade(fx);
    v = fade(fy);
    a = perm[cx] + cy;
    b = perm[(cx + 1) & 255] + cy;
    g00 = grad(perm[a & 255], fx, fy);
    g10 = grad(perm[b & 255], fx - 65536, fy);
    g01 = grad(perm[(a + 1) & 255], fx, fy - 65536);
    g11 = grad(perm[(b + 1) & 255], fx - 65536, fy - 65536);
    return lerp(lerp(g00, g10, u), lerp(g01, g11, u), v);
  endfunction

  function void note_item(logic mode, logic [7:0] idx, logic [7:0] val,
                          logic signed [27:0] x, logic signed [27:0] y);
    longint sum, res, recip;
    if (mode == ogn_pkg::MODE_LOAD) begin
      perm[idx] = val;
      return;
    end
    sum = 0;
    for (int i = 0; i < 4; i++)
      sum += octave_sample(longint'(x) <<< i, longint'(y) <<< i) * (longint'(1) << (3 - i));
    recip = (longint'(1) << 32) / 15 + 1;
    res = (sum * recip) / (longint'(1) << 32);
    if (res > 131072) res = 131072;
    if (res < -131072) res = -131072;
    pending.push_back(19'(res));
  endfunction

  function void check_sample(logic signed [18:0] got);
    logic signed [18:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected sample, expected none, actual %0d", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got !== want) begin
      $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_octave_gradient_noise_2d;
  import ogn_pkg::*;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, mode_i, out_valid_o, out_stall_i;
  logic [7:0] table_index_i, table_value_i;
  logic signed [27:0] coord_x_i, coord_y_i;
  logic signed [18:0] noise_value_o;

  noise_scoreboard sb;
  int cycles;
  int sent;
  int out_wait;  // cycles the receiver still idles before the next item
  bit hold_out;  // receiver hold-off request
  bit random_stall;

  octave_gradient_noise_2d i_dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic send(logic mode, logic [7:0] idx, logic [7:0] val,
                      logic signed [27:0] x, logic signed [27:0] y);
    int gap;
    gap = $urandom_range(3) == 0 ? $urandom_range(6) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    table_index_i <= idx;
    table_value_i <= val;
    coord_x_i <= x;
    coord_y_i <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(mode, idx, val, x, y);
    sent++;
  endtask

  task automatic load_table();
    logic [7:0] p[256];
    int j;
    logic [7:0] t;
    foreach (p[i]) p[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      t = p[i]; p[i] = p[j]; p[j] = t;
    end
    for (int i = 0; i < 256; i++) send(MODE_LOAD, 8'(i), p[i], '0, '0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [27:0] rand_coord();
    case ($urandom_range(3))
      0: return 28'($urandom);
      1: return 28'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
      2: return $urandom_range(1) ? 28'sh7FFFFFF : -28'sh8000000;
      default: return 28'($signed({$urandom_range(255), 16'h0}) + $urandom_range(3) - 1);
    endcase
  endfunction

  // output side: a drawn idle count after each item, plus a long hold when asked
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_sample(noise_value_o);
      out_wait = random_stall ? $urandom_range(6) : 0;
    end
    if (hold_out) begin
      out_stall_i <= 1'b1;
    end else if (out_wait > 0) begin
      out_stall_i <= 1'b1;
      out_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic signed [27:0] dx[10];
    sb = new();
    cycles = 0;
    sent = 0;
    out_wait = 0;
    hold_out = 0;
    random_stall = 0;
    rst_ni = 0;
    in_valid_i = 0;
    out_stall_i = 0;
    mode_i = 0;
    table_index_i = 0;
    table_value_i = 0;
    coord_x_i = 0;
    coord_y_i = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_table();
    dx = '{28'sh7FFFFFF, -28'sh8000000, 28'sd0, 28'sh000FFFF, -28'sd1,
           28'sh0010000, 28'sh0FF8000, -28'sh0010001, 28'sh5555555, 28'sh2AAAAAA};
    foreach (dx[i]) send(MODE_EVAL, '0, '0, dx[i], dx[(i + 3) % 10]);
    drain();
    random_stall = 1;
    // long output hold while the sender keeps offering items
    fork
      begin
        hold_out = 1;
        repeat (60) @(posedge clk_i);
        hold_out = 0;
      end
      for (int i = 0; i < 40; i++)
        send(MODE_EVAL, '0, '0, rand_coord(), rand_coord());
    join
    for (int i = 0; i < 700; i++) begin
      if ($urandom_range(15) == 0)
        send(MODE_LOAD, 8'($urandom), 8'($urandom), rand_coord(), rand_coord());
      else
        send(MODE_EVAL, 8'($urandom), 8'($urandom), rand_coord(), rand_coord());
      if (i == 500) drain();
    end
    drain();
    repeat (30) @(posedge clk_i);
    $display("run sent %0d items, checked %0d noise samples across a shuffled table,",
             sent, sb.checked);
    $display("coordinate extremes, cell edges and table reloads under output stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
